>>> sv/tqe_pkg.sv
package tqe_pkg;

	// Default size of the timer bank, and the number of timers that a 5-bit id can reach.
	localparam int unsigned TIMERS_DEFAULT = 32;
	localparam int unsigned ID_REACH = 32;

	// Expiries reported by one tick at most.
	localparam logic [5:0] MAX_EXPIRIES = 6'd63;

	typedef enum logic [2:0] {
		CMD_CREATE    = 3'd0,
		CMD_SET_IVL   = 3'd1,
		CMD_SET_DEF   = 3'd2,
		CMD_SET_AT    = 3'd3,
		CMD_RUN_CATCH = 3'd4,
		CMD_FOREVER   = 3'd5,
		CMD_RESET     = 3'd6,
		CMD_TICK      = 3'd7
	} command_t;

	typedef enum logic [1:0] {
		KIND_STATUS  = 2'd0,
		KIND_EXPIRY  = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	localparam logic [1:0] MODE_ONESHOT = 2'd0;
	localparam logic [1:0] MODE_CATCHUP = 2'd1;
	localparam logic [1:0] MODE_FOREVER = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic load;
		logic exec_cmd;
		logic scan_clr;
		logic scan_step;
		logic emit_step;
		logic end_step;
		logic emit_summ;
		logic sel_id;
		logic sel_scan;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		logic is_tick;
		logic scan_last;
		logic found;
		logic n_full;
		logic step_emit;
		logic out_free;
	} sts_t;

endpackage

>>> sv/tqe_req_if.sv
interface tqe_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [4:0]  timer_id;
	logic [31:0] time_value;
	logic [31:0] now_ms;
	logic signed [31:0] timeout_in;

	modport source (output valid, command, timer_id, time_value, now_ms, timeout_in,
		input ready);
	modport sink (input valid, command, timer_id, time_value, now_ms, timeout_in,
		output ready);
endinterface

>>> sv/tqe_rsp_if.sv
interface tqe_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [4:0]  timer_index;
	logic        status;
	logic [31:0] wake_count;
	logic signed [31:0] next_timeout;
	logic [5:0]  expired_count;
	logic        last;

	modport source (output valid, kind, timer_index, status, wake_count, next_timeout,
		expired_count, last, input ready);
	modport sink (input valid, kind, timer_index, status, wake_count, next_timeout,
		expired_count, last, output ready);
endinterface

>>> sv/tqe_ctrl.sv
module tqe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  tqe_pkg::sts_t sts,
	output tqe_pkg::ctl_t ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_SCAN,
		ST_DECIDE,
		ST_STEP,
		ST_SUMM
	} state_t;

	state_t state_q;
	state_t state_nx;

	// Decode of the current state and status into datapath commands and the next state.
	always_comb begin
		ctl = '0;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				ctl.take = 1'b1;
				if (sts.in_valid) begin
					ctl.load = 1'b1;
					if (sts.is_tick) begin
						ctl.scan_clr = 1'b1;
						state_nx = ST_SCAN;
					end else begin
						state_nx = ST_CMD;
					end
				end
			end
			ST_CMD: begin
				ctl.sel_id = 1'b1;
				if (sts.out_free) begin
					ctl.exec_cmd = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			ST_SCAN: begin
				ctl.sel_scan = 1'b1;
				ctl.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_nx = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_nx = (sts.found && !sts.n_full) ? ST_STEP : ST_SUMM;
			end
			ST_STEP: begin
				if (sts.step_emit) begin
					if (sts.out_free) begin
						ctl.emit_step = 1'b1;
					end
				end else begin
					ctl.end_step = 1'b1;
					ctl.scan_clr = 1'b1;
					state_nx = ST_SCAN;
				end
			end
			ST_SUMM: begin
				if (sts.out_free) begin
					ctl.emit_summ = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

>>> sv/tqe_dp.sv
module tqe_dp #(
	parameter int unsigned TIMERS = tqe_pkg::TIMERS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tqe_pkg::ctl_t ctl,
	output tqe_pkg::sts_t sts,
	tqe_req_if.sink       req,
	tqe_rsp_if.source     rsp
);

	// Only the timers that a 5-bit id can reach are ever armed, so only they are stored.
	localparam int unsigned NT = (TIMERS < tqe_pkg::ID_REACH) ? TIMERS : tqe_pkg::ID_REACH;
	localparam int unsigned IW = $clog2(NT);

	// Latched input item.
	logic [2:0]  cmd_q;
	logic [4:0]  id_q;
	logic [31:0] tv_q;
	logic [31:0] now_q;
	logic [31:0] tin_q;

	// Timer bank.
	logic [31:0] dl_q   [NT];
	logic [31:0] dur_q  [NT];
	logic        arm_q  [NT];
	logic [1:0]  mode_q [NT];
	logic [31:0] wk_q   [NT];

	// Scan and tick state.
	logic [IW-1:0] idx_q;
	logic [IW-1:0] best_q;
	logic          found_q;
	logic [31:0]   bd_q;
	logic          nv_q;
	logic [30:0]   nxt_q;
	logic          first_q;
	logic [5:0]    n_q;

	// Output register.
	logic        ov_q;
	logic [1:0]  okind_q;
	logic [4:0]  oidx_q;
	logic        ostat_q;
	logic [31:0] owk_q;
	logic [31:0] ont_q;
	logic [5:0]  ocnt_q;
	logic        olast_q;

	logic [IW-1:0] addr;
	logic [31:0]   r_dl;
	logic [31:0]   r_dur;
	logic          r_arm;
	logic [1:0]    r_mode;
	logic [31:0]   r_wk;
	logic [31:0]   diff;
	logic          due;
	logic [30:0]   clamp;
	logic          id_ok;
	logic          dur_zero;
	logic          out_free;

	logic          we;
	logic [31:0]   w_dl;
	logic [31:0]   w_dur;
	logic          w_arm;
	logic [1:0]    w_mode;
	logic [31:0]   w_wk;
	logic          cmd_err;
	logic [31:0]   summ_nt;

	// One read address into the bank, chosen by the phase of the work.
	always_comb begin
		if (ctl.sel_id) begin
			addr = id_q[IW-1:0];
		end else if (ctl.sel_scan) begin
			addr = idx_q;
		end else begin
			addr = best_q;
		end
	end

	assign r_dl     = dl_q[addr];
	assign r_dur    = dur_q[addr];
	assign r_arm    = arm_q[addr];
	assign r_mode   = mode_q[addr];
	assign r_wk     = wk_q[addr];
	assign diff     = r_dl - now_q;
	assign due      = diff[31] || (diff == 32'd0);
	assign clamp    = diff[31] ? 31'd0 : diff[30:0];
	assign id_ok    = (32'(id_q) < 32'(TIMERS));
	assign dur_zero = (r_dur == 32'd0);
	assign out_free = !ov_q || rsp.ready;

	assign req.ready = ctl.take;

	// Status back to the controller.
	always_comb begin
		sts.in_valid  = req.valid;
		sts.is_tick   = (req.command == tqe_pkg::CMD_TICK);
		sts.scan_last = (idx_q == IW'(NT - 1));
		sts.found     = found_q;
		sts.n_full    = (n_q == tqe_pkg::MAX_EXPIRIES);
		sts.out_free  = out_free;
		if (r_mode == tqe_pkg::MODE_CATCHUP) begin
			sts.step_emit = !dur_zero && (n_q != tqe_pkg::MAX_EXPIRIES) && due;
		end else begin
			sts.step_emit = first_q;
		end
	end

	// New contents of the addressed timer for a command or an expiry step.
	always_comb begin
		we      = 1'b0;
		w_dl    = r_dl;
		w_dur   = r_dur;
		w_arm   = r_arm;
		w_mode  = r_mode;
		w_wk    = r_wk;
		cmd_err = 1'b0;
		if (ctl.exec_cmd) begin
			if (!id_ok) begin
				cmd_err = 1'b1;
			end else begin
				case (cmd_q)
					tqe_pkg::CMD_CREATE: begin
						w_dur  = tv_q;
						w_dl   = 32'd0;
						w_arm  = 1'b0;
						w_mode = tqe_pkg::MODE_ONESHOT;
						w_wk   = 32'd0;
					end
					tqe_pkg::CMD_SET_IVL: begin
						w_dl  = now_q + tv_q;
						w_arm = 1'b1;
					end
					tqe_pkg::CMD_SET_DEF: begin
						if (dur_zero) begin
							cmd_err = 1'b1;
						end else begin
							w_dl  = now_q + r_dur;
							w_arm = 1'b1;
						end
					end
					tqe_pkg::CMD_SET_AT: begin
						w_dl  = tv_q;
						w_arm = 1'b1;
					end
					tqe_pkg::CMD_RUN_CATCH, tqe_pkg::CMD_FOREVER: begin
						if (dur_zero) begin
							cmd_err = 1'b1;
						end else begin
							w_mode = (cmd_q == tqe_pkg::CMD_RUN_CATCH)
								? tqe_pkg::MODE_CATCHUP : tqe_pkg::MODE_FOREVER;
							w_wk   = 32'd0;
							w_dl   = now_q + r_dur;
							w_arm  = 1'b1;
						end
					end
					default: begin
						w_arm  = 1'b0;
						w_mode = tqe_pkg::MODE_ONESHOT;
					end
				endcase
				we = !cmd_err;
			end
		end else if (ctl.emit_step) begin
			we = 1'b1;
			if (r_mode == tqe_pkg::MODE_CATCHUP) begin
				w_dl = r_dl + r_dur;
				w_wk = r_wk + 32'd1;
			end else if (r_mode == tqe_pkg::MODE_FOREVER) begin
				w_dl = now_q + r_dur;
				w_wk = r_wk + 32'd1;
			end else begin
				w_dl  = now_q;
				w_arm = 1'b0;
			end
		end else if (ctl.end_step) begin
			// A catch-up timer with no duration is dropped without an expiry.
			if ((r_mode == tqe_pkg::MODE_CATCHUP) && dur_zero) begin
				we    = 1'b1;
				w_arm = 1'b0;
			end
		end
	end

	// Summary timeout: the sooner of the poll timeout and the next deadline.
	always_comb begin
		summ_nt = nv_q ? {1'b0, nxt_q} : 32'hFFFF_FFFF;
		if (!tin_q[31] && (!nv_q || (tin_q[30:0] < nxt_q))) begin
			summ_nt = tin_q;
		end
	end

	// Timer bank write port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) begin
				dl_q[i]   <= 32'd0;
				dur_q[i]  <= 32'd0;
				arm_q[i]  <= 1'b0;
				mode_q[i] <= tqe_pkg::MODE_ONESHOT;
				wk_q[i]   <= 32'd0;
			end
		end else if (we) begin
			dl_q[addr]   <= w_dl;
			dur_q[addr]  <= w_dur;
			arm_q[addr]  <= w_arm;
			mode_q[addr] <= w_mode;
			wk_q[addr]   <= w_wk;
		end
	end

	// Input item latch.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req.command;
			id_q  <= req.timer_id;
			tv_q  <= req.time_value;
			now_q <= req.now_ms;
			tin_q <= req.timeout_in;
		end
	end

	// Scan over the bank: most overdue due timer and nearest deadline; also the expiry count of a tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			best_q  <= '0;
			found_q <= 1'b0;
			bd_q    <= 32'd0;
			nv_q    <= 1'b0;
			nxt_q   <= 31'd0;
			first_q <= 1'b0;
			n_q     <= 6'd0;
		end else begin
			if (ctl.load) begin
				n_q <= 6'd0;
			end else if (ctl.emit_step) begin
				n_q <= n_q + 6'd1;
			end
			if (ctl.scan_clr) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				nv_q    <= 1'b0;
				first_q <= 1'b1;
			end else if (ctl.scan_step) begin
				idx_q <= idx_q + IW'(1);
				if (r_arm) begin
					if (due && (!found_q || ($signed(diff) < $signed(bd_q)))) begin
						found_q <= 1'b1;
						best_q  <= idx_q;
						bd_q    <= diff;
					end
					if (!nv_q || (clamp < nxt_q)) begin
						nv_q  <= 1'b1;
						nxt_q <= clamp;
					end
				end
			end else if (ctl.emit_step) begin
				first_q <= 1'b0;
			end
		end
	end

	// Output register: holds one result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ctl.exec_cmd || ctl.emit_step || ctl.emit_summ) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec_cmd) begin
			okind_q <= tqe_pkg::KIND_STATUS;
			oidx_q  <= id_q;
			ostat_q <= cmd_err;
			owk_q   <= id_ok ? w_wk : 32'd0;
			ont_q   <= 32'd0;
			ocnt_q  <= 6'd0;
			olast_q <= 1'b1;
		end else if (ctl.emit_step) begin
			okind_q <= tqe_pkg::KIND_EXPIRY;
			oidx_q  <= 5'(best_q);
			ostat_q <= 1'b0;
			owk_q   <= w_wk;
			ont_q   <= 32'd0;
			ocnt_q  <= n_q + 6'd1;
			olast_q <= 1'b0;
		end else if (ctl.emit_summ) begin
			okind_q <= tqe_pkg::KIND_SUMMARY;
			oidx_q  <= 5'd0;
			ostat_q <= 1'b0;
			owk_q   <= 32'd0;
			ont_q   <= summ_nt;
			ocnt_q  <= n_q;
			olast_q <= 1'b1;
		end
	end

	assign rsp.valid         = ov_q;
	assign rsp.kind          = okind_q;
	assign rsp.timer_index   = oidx_q;
	assign rsp.status        = ostat_q;
	assign rsp.wake_count    = owk_q;
	assign rsp.next_timeout  = ont_q;
	assign rsp.expired_count = ocnt_q;
	assign rsp.last          = olast_q;

endmodule

>>> sv/timer_queue_expiry.sv
// Channel  Role    Contents
// req      sink    command, timer_id, time_value, now_ms, timeout_in
// rsp      source  kind, timer_index, status, wake_count, next_timeout,
//                  expired_count, last
//
// A command is taken in the idle state and its status result is registered once the output
// register is free; no further command is taken before that.
// A tick is taken, then every stored timer is scanned and a decision is made; each expired
// timer then gives an expiry result, followed by a fresh scan and decision, and a catch-up
// timer gives one more expiry result for each further missed interval. The summary result
// comes last.
// Reset clears the whole bank at once; the first item may follow straight after.
// A stalled result holds the block in place; no new item is taken until the last
// result of the current one has been produced.
module timer_queue_expiry #(
	parameter int unsigned TIMERS = tqe_pkg::TIMERS_DEFAULT
) (
	input logic       clk,
	input logic       arst_n,
	tqe_req_if.sink   req,
	tqe_rsp_if.source rsp
);

	tqe_pkg::ctl_t ctl;
	tqe_pkg::sts_t sts;

	tqe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	tqe_dp #(
		.TIMERS (TIMERS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
